### rtl/core/sha1sh_pkg.sv
`timescale 1ns / 1ps

package sha1sh_pkg;

   localparam int WordW      = 32;
   localparam int ChainWords = 5;
   localparam int SchedWords = 16;
   localparam int CountW     = 61;
   localparam int RoundW     = 7;
   localparam int PosW       = 6;
   localparam int LenW       = 64;

   typedef logic [WordW-1:0] word_type;
   typedef logic [ChainWords-1:0][WordW-1:0] chain_type;

   localparam word_type InitChain [ChainWords] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam word_type RoundK [4] = '{
      32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
   };

   localparam logic [7:0]        PadByte     = 8'h80;
   localparam logic [PosW-1:0]   LastPos     = 6'd63;
   localparam logic [PosW-1:0]   LenStartPos = 6'd56;
   localparam logic [RoundW-1:0] LastRound   = 7'd79;
   localparam logic [RoundW-1:0] Phase1Start = 7'd20;
   localparam logic [RoundW-1:0] Phase2Start = 7'd40;
   localparam logic [RoundW-1:0] Phase3Start = 7'd60;

   localparam logic [1:0] PhaseChoose = 2'd0;
   localparam logic [1:0] PhaseParity = 2'd1;
   localparam logic [1:0] PhaseMajor  = 2'd2;
   localparam logic [1:0] PhaseLast   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_LEN,
      ST_DONE
   } state_type;

   // Control from the sequencer to the schedule window and the round unit.
   typedef struct packed {
      logic            byte_wr;
      logic [PosW-1:0] byte_pos;
      logic [7:0]      byte_val;
      logic            len_wr;
      logic [LenW-1:0] len_bits;
      logic            shift;
      logic            clear;
      logic            load;
      logic            step;
      logic [1:0]      phase;
      logic            add;
      logic            init;
   } ctl_type;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      return (x << n) | (x >> (WordW - n));
   endfunction

   function automatic word_type round_f(input logic [1:0] phase, input word_type b,
                                        input word_type c, input word_type d);
      word_type f;
      case (phase)
         PhaseChoose: f = d ^ (b & (c ^ d));
         PhaseMajor:  f = (b & c) | (d & (b | c));
         default:     f = b ^ c ^ d;
      endcase
      return f;
   endfunction

endpackage

### rtl/core/sha1sh_req_if.sv
`timescale 1ns / 1ps

interface sha1sh_req_if;
   logic       valid;
   logic       ready;
   logic       byte_present;
   logic [7:0] msg_byte;
   logic       end_of_message;

   modport source (output valid, output byte_present, output msg_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input byte_present, input msg_byte,
                   input end_of_message, output ready);
endinterface

### rtl/core/sha1sh_rsp_if.sv
`timescale 1ns / 1ps

interface sha1sh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word_0;
   logic [31:0] digest_word_1;
   logic [31:0] digest_word_2;
   logic [31:0] digest_word_3;
   logic [31:0] digest_word_4;

   modport source (output valid, output digest_word_0, output digest_word_1,
                   output digest_word_2, output digest_word_3, output digest_word_4,
                   input ready);
   modport sink   (input valid, input digest_word_0, input digest_word_1,
                   input digest_word_2, input digest_word_3, input digest_word_4,
                   output ready);
endinterface

### rtl/core/sha1sh_sched.sv
`timescale 1ns / 1ps

// Sixteen-word message window: packs bytes, takes the padding and length,
// and slides one word per round while expanding the schedule.
module sha1sh_sched (
   input  logic                clock,
   input  logic                reset,
   input  sha1sh_pkg::ctl_type ctl,
   output sha1sh_pkg::word_type w_cur
);

   sha1sh_pkg::word_type win_ff [sha1sh_pkg::SchedWords];
   sha1sh_pkg::word_type win_in [sha1sh_pkg::SchedWords];
   logic [4:0] lane_shift;

   assign lane_shift = {~ctl.byte_pos[1:0], 3'b000};

   always_comb begin
      for (int i = 0; i < sha1sh_pkg::SchedWords; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctl.clear) begin
         for (int i = 0; i < sha1sh_pkg::SchedWords; i++) begin
            win_in[i] = '0;
         end
      end else begin
         if (ctl.shift) begin
            for (int i = 0; i < sha1sh_pkg::SchedWords - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[sha1sh_pkg::SchedWords-1] =
               sha1sh_pkg::rotl(win_ff[13] ^ win_ff[8] ^ win_ff[2] ^ win_ff[0], 1);
         end
         if (ctl.byte_wr) begin
            win_in[ctl.byte_pos[5:2]][lane_shift +: 8] = ctl.byte_val;
         end
         if (ctl.len_wr) begin
            win_in[14] = ctl.len_bits[63:32];
            win_in[15] = ctl.len_bits[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < sha1sh_pkg::SchedWords; i++) begin
         if (reset) begin
            win_ff[i] <= '0;
         end else begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   assign w_cur = win_ff[0];

endmodule

### rtl/core/sha1sh_round.sv
`timescale 1ns / 1ps

// Shared round unit: one SHA-1 round per step, plus the chaining registers.
module sha1sh_round (
   input  logic                  clock,
   input  logic                  reset,
   input  sha1sh_pkg::ctl_type   ctl,
   input  sha1sh_pkg::word_type  w_cur,
   output sha1sh_pkg::chain_type chain_value
);

   sha1sh_pkg::chain_type chain_ff, chain_in;
   sha1sh_pkg::chain_type work_ff, work_in;
   sha1sh_pkg::word_type  temp;

   assign temp = sha1sh_pkg::rotl(work_ff[0], 5)
               + sha1sh_pkg::round_f(ctl.phase, work_ff[1], work_ff[2], work_ff[3])
               + work_ff[4] + sha1sh_pkg::RoundK[ctl.phase] + w_cur;

   always_comb begin
      work_in  = work_ff;
      chain_in = chain_ff;
      if (ctl.load) begin
         work_in = chain_ff;
      end else if (ctl.step) begin
         work_in[4] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = sha1sh_pkg::rotl(work_ff[1], 30);
         work_in[1] = work_ff[0];
         work_in[0] = temp;
      end
      if (ctl.init) begin
         for (int i = 0; i < sha1sh_pkg::ChainWords; i++) begin
            chain_in[i] = sha1sh_pkg::InitChain[i];
         end
      end else if (ctl.add) begin
         for (int i = 0; i < sha1sh_pkg::ChainWords; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         for (int i = 0; i < sha1sh_pkg::ChainWords; i++) begin
            chain_ff[i] <= sha1sh_pkg::InitChain[i];
         end
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain_value = chain_ff;

endmodule

### rtl/core/sha1_stream_hasher_unit.sv
// SHA-1 over a byte stream, one byte word per handshake; one word in flight at a time.
// A plain byte is stored at once; the 64th byte of a block holds off req while the 80 rounds
// run in the shared round unit and the chain add follows. An end word goes on through padding,
// rounds and chain add to its digest word, with a length block as well if the padding spills.
// Throughput is bound by the single round unit: 80 rounds per 64-byte block.
// Reset (synchronous, active high) loads the initial chain and clears the count and window.
`timescale 1ns / 1ps

module sha1_stream_hasher_unit (
   input logic          clock,
   input logic          reset,
   sha1sh_req_if.sink   req,
   sha1sh_rsp_if.source rsp
);

   // Sequencer state. The follow register tells where to go once a block's
   // chain add is done: back to idle, on to padding, to the length block,
   // or to digest output.
   sha1sh_pkg::state_type state_ff, state_in;
   sha1sh_pkg::state_type follow_ff, follow_in;

   logic [sha1sh_pkg::RoundW-1:0] round_ff, round_in;
   logic [sha1sh_pkg::CountW-1:0] count_ff, count_in;
   logic [sha1sh_pkg::PosW-1:0]   pos;

   logic                  rsp_valid_ff, rsp_valid_in;
   sha1sh_pkg::chain_type digest_ff, digest_in;

   sha1sh_pkg::ctl_type   ctl;
   sha1sh_pkg::word_type  w_cur;
   sha1sh_pkg::chain_type chain_value;

   // The fill position within the current block is the low part of the byte count.
   assign pos = count_ff[sha1sh_pkg::PosW-1:0];

   always_comb begin
      state_in     = state_ff;
      follow_in    = follow_ff;
      round_in     = round_ff;
      count_in     = count_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      req.ready    = 1'b0;

      ctl          = '0;
      ctl.byte_pos = pos;
      ctl.len_bits = {count_ff, 3'b000};

      // Round function selection follows the round index in four groups of twenty.
      if (round_ff < sha1sh_pkg::Phase1Start) begin
         ctl.phase = sha1sh_pkg::PhaseChoose;
      end else if (round_ff < sha1sh_pkg::Phase2Start) begin
         ctl.phase = sha1sh_pkg::PhaseParity;
      end else if (round_ff < sha1sh_pkg::Phase3Start) begin
         ctl.phase = sha1sh_pkg::PhaseMajor;
      end else begin
         ctl.phase = sha1sh_pkg::PhaseLast;
      end

      case (state_ff)
         sha1sh_pkg::ST_IDLE: begin
            // Ready is high throughout idle, so a valid word is taken at once.
            req.ready = 1'b1;
            if (req.valid) begin
               if (req.byte_present) begin
                  // Store the byte in its big-endian lane; a full block starts
                  // the rounds right away.
                  ctl.byte_wr  = 1'b1;
                  ctl.byte_val = req.msg_byte;
                  count_in     = count_ff + 1'b1;
                  if (pos == sha1sh_pkg::LastPos) begin
                     ctl.load  = 1'b1;
                     state_in  = sha1sh_pkg::ST_ROUND;
                     follow_in = req.end_of_message ? sha1sh_pkg::ST_PAD
                                                    : sha1sh_pkg::ST_IDLE;
                  end else if (req.end_of_message) begin
                     state_in = sha1sh_pkg::ST_PAD;
                  end
               end else if (req.end_of_message) begin
                  state_in = sha1sh_pkg::ST_PAD;
               end
            end
         end
         sha1sh_pkg::ST_ROUND: begin
            ctl.step  = 1'b1;
            ctl.shift = 1'b1;
            round_in  = round_ff + 1'b1;
            if (round_ff == sha1sh_pkg::LastRound) begin
               round_in = '0;
               state_in = sha1sh_pkg::ST_ADD;
            end
         end
         sha1sh_pkg::ST_ADD: begin
            // Fold the working variables into the chain and empty the window
            // so that zero fill of the next block comes for free.
            ctl.add   = 1'b1;
            ctl.clear = 1'b1;
            state_in  = follow_ff;
         end
         sha1sh_pkg::ST_PAD: begin
            // The 0x80 marker goes at the fill position. If the length still
            // fits behind it, it is written in the same cycle.
            ctl.byte_wr  = 1'b1;
            ctl.byte_val = sha1sh_pkg::PadByte;
            ctl.load     = 1'b1;
            state_in     = sha1sh_pkg::ST_ROUND;
            if (pos >= sha1sh_pkg::LenStartPos) begin
               follow_in = sha1sh_pkg::ST_LEN;
            end else begin
               ctl.len_wr = 1'b1;
               follow_in  = sha1sh_pkg::ST_DONE;
            end
         end
         sha1sh_pkg::ST_LEN: begin
            ctl.len_wr = 1'b1;
            ctl.load   = 1'b1;
            state_in   = sha1sh_pkg::ST_ROUND;
            follow_in  = sha1sh_pkg::ST_DONE;
         end
         sha1sh_pkg::ST_DONE: begin
            // Wait for the output register to free up, then hand over the
            // digest and start afresh for the next message.
            if (!rsp_valid_ff || rsp.ready) begin
               digest_in    = chain_value;
               rsp_valid_in = 1'b1;
               ctl.init     = 1'b1;
               count_in     = '0;
               state_in     = sha1sh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1sh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
      follow_ff <= follow_in;
      if (reset) begin
         state_ff     <= sha1sh_pkg::ST_IDLE;
         round_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   sha1sh_sched u_sched (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .w_cur (w_cur)
   );

   sha1sh_round u_round (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .w_cur       (w_cur),
      .chain_value (chain_value)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.digest_word_0 = digest_ff[0];
   assign rsp.digest_word_1 = digest_ff[1];
   assign rsp.digest_word_2 = digest_ff[2];
   assign rsp.digest_word_3 = digest_ff[3];
   assign rsp.digest_word_4 = digest_ff[4];

endmodule
